// ----- rtl/ibd_neg_log_likelihood_unit_assert.svh -----
// assertion macros used by the checker of the negative log likelihood unit
// no dependencies; included by the checker file
`ifndef IBD_NEG_LOG_LIKELIHOOD_UNIT_ASSERT_SVH
`define IBD_NEG_LOG_LIKELIHOOD_UNIT_ASSERT_SVH

// same-cycle implication
`define NLL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nll assertion failed");

// next-cycle implication
`define NLL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nll assertion failed");

`endif

// ----- rtl/ibd_nll_pkg.sv -----
// constants, register indexes and state type of the negative log likelihood unit
// no dependencies; used by the top level and its checker
package ibd_nll_pkg;

    localparam int OUT_W       = 48;
    localparam int OUT_FRAC    = 16;
    localparam logic [OUT_W-1:0] SENTINEL = OUT_W'(100000) << OUT_FRAC;

    localparam int FRAC_ROUNDS = 20;
    localparam int MANT_FRAC   = 30;
    localparam int MANT_W      = MANT_FRAC + 1;
    localparam int DIGIT_W     = 3;
    localparam int MC_W        = 32;
    localparam int ACC_W       = 36;
    localparam int SQ_DIGITS   = MANT_FRAC / DIGIT_W;
    localparam int DIFF_W      = 27;
    localparam int LN_DIGITS   = DIFF_W / DIGIT_W;
    localparam int LN_SHIFT    = 36 - LN_DIGITS * DIGIT_W;
    localparam int DCNT_W      = 4;
    localparam int RND_W       = 5;

    localparam logic [MC_W-1:0]  LN2_Q32  = 32'd2977044472;
    localparam logic [ACC_W-1:0] LN_ROUND = ACC_W'(1) << (LN_DIGITS * DIGIT_W + LN_SHIFT - 1);

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t REG_WEIGHT_IBD1 = 1'b0;
    localparam cfg_idx_t REG_WEIGHT_IBD2 = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WSUM,
        ST_CHECK,
        ST_NORM,
        ST_SQUARE,
        ST_SCALE,
        ST_ACCUM,
        ST_FINISH
    } nll_state_t;

endpackage

// ----- rtl/ibd_neg_log_likelihood_unit.sv -----
// negative log likelihood of a kinship hypothesis over a stream of snp items
// depends on ibd_nll_pkg
//
// One item per SNP enters on the s_axis side; after the item marked tlast one result leaves
// on the m_axis side with the Q32.16 total, or the sentinel 100000.0 with tuser set when the
// weights are invalid, 4*k2*k0 >= k1^2, a zero weighted sum was seen or the total saturated.
// Items are worked one at a time. The weighted sum takes one weight bit per cycle. A masked
// item, or one whose sum is zero or at least 1.0, holds s_axis_tready low only through the
// weighted sum, the check and the finish state. Any other item adds a normalizing shift of
// one bit per cycle and the 3-bit-per-cycle serial multiplier, which runs 20 squaring rounds
// of 11 steps and a 9-step scale by ln 2, then an accumulate step. A finished result is held
// in an output register while the next item is taken; a tlast item whose result is ready
// waits until the previous result has been read.
module ibd_neg_log_likelihood_unit #(
    parameter int PROB_BITS   = 24,
    parameter int WEIGHT_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  ibd_nll_pkg::cfg_idx_t                 cfg_addr,
    input  logic [WEIGHT_BITS:0]                  cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // prob_ibd0, prob_ibd1, prob_ibd2, zero fill
    input  logic [((3*(PROB_BITS+1)+7)/8)*8-1:0]  s_axis_tdata,
    // masked
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // neg_log_likelihood
    output logic [ibd_nll_pkg::OUT_W-1:0]         m_axis_tdata,
    // penalized
    output logic                                  m_axis_tuser
);
    import ibd_nll_pkg::*;

    localparam int PW     = PROB_BITS + 1;
    localparam int KW     = WEIGHT_BITS + 1;
    localparam int FB     = PROB_BITS + WEIGHT_BITS;
    localparam int SW     = FB + 4;
    localparam int KK     = 2 * KW;
    localparam int ZW     = $clog2(FB + 1);
    localparam int WCNT_W = $clog2(KW);
    localparam logic [KW-1:0] K_ONE = {1'b1, {WEIGHT_BITS{1'b0}}};

    nll_state_t state_reg, state_next;

    logic [KW-1:0]       weight1_reg, weight2_reg;
    logic [PW-1:0]       p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic                masked_reg, masked_next, last_reg, last_next;
    logic [KW-1:0]       k1_reg, k1_next, k2_reg, k2_next;
    logic                k0neg_reg, k0neg_next;
    logic [KW-1:0]       ks0_reg, ks0_next, ks1_reg, ks1_next, ks2_reg, ks2_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [KK-1:0]       c_reg, c_next, d_reg, d_next;
    logic [WCNT_W-1:0]   wcnt_reg, wcnt_next;
    logic [FB-1:0]       norm_reg, norm_next;
    logic [ZW-1:0]       z_reg, z_next;
    logic [MC_W-1:0]     mc_reg, mc_next, mp_reg, mp_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [RND_W-1:0]    rnd_reg, rnd_next;
    logic [FRAC_ROUNDS-1:0] f_reg, f_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic                inf_reg, inf_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;
    logic                out_pen_reg, out_pen_next;
    logic                m_valid_reg, m_valid_next;

    logic [MC_W+DIGIT_W-1:0] mul_prod;
    logic [ACC_W-1:0]        mul_sum, mul_shift;
    logic [FB+MANT_FRAC-1:0] norm_ext;
    logic [MANT_W-1:0]       mant;
    logic [KW:0]             k_sum;
    logic [MC_W-1:0]         sq_prod;
    logic                    sq_fbit;
    logic [MANT_W-1:0]       sq_mant;
    logic [FRAC_ROUNDS-1:0]  f_new;
    logic [DIFF_W-1:0]       diff;
    logic [ACC_W-LN_SHIFT-1:0] add_val;
    logic [SUM_BITS:0]       sum_ext;
    logic [OUT_W+SUM_BITS-1:0] sum_wide;
    logic                    pen;

    // serial multiplier: one 3-bit digit of mp per cycle
    assign mul_prod  = {{DIGIT_W{1'b0}}, mc_reg} * {{MC_W{1'b0}}, mp_reg[DIGIT_W-1:0]};
    assign mul_sum   = acc_reg + ACC_W'(mul_prod);
    assign mul_shift = mul_sum >> DIGIT_W;

    assign norm_ext = {norm_reg, {MANT_FRAC{1'b0}}};
    assign mant     = norm_ext[FB+MANT_FRAC-1 -: MANT_W];

    assign sq_prod  = mul_sum[MC_W-1:0];
    assign sq_fbit  = sq_prod[MC_W-1];
    assign sq_mant  = sq_fbit ? sq_prod[MC_W-1:1] : sq_prod[MC_W-2:0];
    assign f_new    = {f_reg[FRAC_ROUNDS-2:0], sq_fbit};
    assign diff     = ((DIFF_W'(z_reg) + DIFF_W'(1)) << FRAC_ROUNDS) - DIFF_W'(f_new);

    assign add_val  = acc_reg[ACC_W-1:LN_SHIFT];
    assign sum_ext  = {1'b0, sum_reg} + (SUM_BITS+1)'(add_val);
    assign sum_wide = {{OUT_W{1'b0}}, sum_reg};

    assign k_sum    = {1'b0, weight1_reg} + {1'b0, weight2_reg};

    assign pen = k0neg_reg || (k1_reg > K_ONE) || (k2_reg > K_ONE)
              || ({c_reg, 2'b00} >= {2'b00, d_reg})
              || inf_reg || (sum_reg == {SUM_BITS{1'b1}});

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_pen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight1_reg <= '0;
            weight2_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WEIGHT_IBD1: weight1_reg <= cfg_wdata;
                REG_WEIGHT_IBD2: weight2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            inf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            inf_reg     <= inf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        masked_reg   <= masked_next;
        last_reg     <= last_next;
        k1_reg       <= k1_next;
        k2_reg       <= k2_next;
        k0neg_reg    <= k0neg_next;
        ks0_reg      <= ks0_next;
        ks1_reg      <= ks1_next;
        ks2_reg      <= ks2_next;
        s_reg        <= s_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        wcnt_reg     <= wcnt_next;
        norm_reg     <= norm_next;
        z_reg        <= z_next;
        mc_reg       <= mc_next;
        mp_reg       <= mp_next;
        acc_reg      <= acc_next;
        dcnt_reg     <= dcnt_next;
        rnd_reg      <= rnd_next;
        f_reg        <= f_next;
        out_data_reg <= out_data_next;
        out_pen_reg  <= out_pen_next;
    end

    always_comb begin
        state_next    = state_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        masked_next   = masked_reg;
        last_next     = last_reg;
        k1_next       = k1_reg;
        k2_next       = k2_reg;
        k0neg_next    = k0neg_reg;
        ks0_next      = ks0_reg;
        ks1_next      = ks1_reg;
        ks2_next      = ks2_reg;
        s_next        = s_reg;
        c_next        = c_reg;
        d_next        = d_reg;
        wcnt_next     = wcnt_reg;
        norm_next     = norm_reg;
        z_next        = z_reg;
        mc_next       = mc_reg;
        mp_next       = mp_reg;
        acc_next      = acc_reg;
        dcnt_next     = dcnt_reg;
        rnd_next      = rnd_reg;
        f_next        = f_reg;
        sum_next      = sum_reg;
        inf_next      = inf_reg;
        out_data_next = out_data_reg;
        out_pen_next  = out_pen_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    p0_next     = s_axis_tdata[PW-1:0];
                    p1_next     = s_axis_tdata[2*PW-1:PW];
                    p2_next     = s_axis_tdata[3*PW-1:2*PW];
                    masked_next = s_axis_tuser;
                    last_next   = s_axis_tlast;
                    k1_next     = weight1_reg;
                    k2_next     = weight2_reg;
                    k0neg_next  = k_sum > {1'b0, K_ONE};
                    ks0_next    = (k_sum > {1'b0, K_ONE}) ? '0 : KW'({1'b0, K_ONE} - k_sum);
                    ks1_next    = weight1_reg;
                    ks2_next    = weight2_reg;
                    s_next      = '0;
                    c_next      = '0;
                    d_next      = '0;
                    wcnt_next   = '0;
                    state_next  = ST_WSUM;
                end
            end
            ST_WSUM: begin
                // msb-first shift-add over the weight bits
                s_next = (s_reg << 1)
                       + (ks0_reg[KW-1] ? SW'(p0_reg) : '0)
                       + (ks1_reg[KW-1] ? SW'(p1_reg) : '0)
                       + (ks2_reg[KW-1] ? SW'(p2_reg) : '0);
                c_next = (c_reg << 1) + (ks0_reg[KW-1] ? KK'(k2_reg) : '0);
                d_next = (d_reg << 1) + (ks1_reg[KW-1] ? KK'(k1_reg) : '0);
                ks0_next  = ks0_reg << 1;
                ks1_next  = ks1_reg << 1;
                ks2_next  = ks2_reg << 1;
                wcnt_next = wcnt_reg + WCNT_W'(1);
                if (wcnt_reg == WCNT_W'(KW - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (masked_reg) begin
                    state_next = ST_FINISH;
                end else if (s_reg == '0) begin
                    inf_next   = 1'b1;
                    state_next = ST_FINISH;
                end else if (s_reg[SW-1:FB] != '0) begin
                    state_next = ST_FINISH;
                end else begin
                    norm_next  = s_reg[FB-1:0];
                    z_next     = '0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if (norm_reg[FB-1]) begin
                    mc_next    = MC_W'(mant);
                    mp_next    = MC_W'(mant);
                    acc_next   = '0;
                    dcnt_next  = '0;
                    rnd_next   = '0;
                    f_next     = '0;
                    state_next = ST_SQUARE;
                end else begin
                    norm_next = norm_reg << 1;
                    z_next    = z_reg + ZW'(1);
                end
            end
            ST_SQUARE: begin
                if (dcnt_reg == DCNT_W'(SQ_DIGITS)) begin
                    // top mantissa bit, no shift: product is m*m >> 30
                    f_next    = f_new;
                    rnd_next  = rnd_reg + RND_W'(1);
                    dcnt_next = '0;
                    if (rnd_reg == RND_W'(FRAC_ROUNDS - 1)) begin
                        mc_next    = LN2_Q32;
                        mp_next    = MC_W'(diff);
                        acc_next   = LN_ROUND;
                        state_next = ST_SCALE;
                    end else begin
                        mc_next  = MC_W'(sq_mant);
                        mp_next  = MC_W'(sq_mant);
                        acc_next = '0;
                    end
                end else begin
                    acc_next  = mul_shift;
                    mp_next   = mp_reg >> DIGIT_W;
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                end
            end
            ST_SCALE: begin
                acc_next  = mul_shift;
                mp_next   = mp_reg >> DIGIT_W;
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(LN_DIGITS - 1)) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                sum_next   = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_axis_tready) begin
                    out_data_next = pen ? SENTINEL : sum_wide[OUT_W-1:0];
                    out_pen_next  = pen;
                    m_valid_next  = 1'b1;
                    sum_next      = '0;
                    inf_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/ibd_nll_checker.sv -----
// port-level checks of the negative log likelihood unit, bound to its top level
// depends on ibd_nll_pkg and ibd_neg_log_likelihood_unit_assert.svh
`include "ibd_neg_log_likelihood_unit_assert.svh"

module ibd_nll_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ibd_nll_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);
    import ibd_nll_pkg::*;

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    `NLL_ASSERT_NXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `NLL_ASSERT_NXT(a_busy_after_item, aclk, aresetn, s_acc, !s_axis_tready)
    `NLL_ASSERT_IMP(a_penalty_sentinel, aclk, aresetn, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == SENTINEL)
    `NLL_ASSERT_NXT(a_no_instant_result, aclk, aresetn, s_acc, !$rose(m_axis_tvalid))

endmodule

bind ibd_neg_log_likelihood_unit ibd_nll_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
